### sv/dvba_pkg.sv
// ----------------------------------------------------------------------------
// dvba_pkg
// Shared widths, codes and payload types of the distinct value bin assigner.
// ----------------------------------------------------------------------------
package dvba_pkg;

   localparam int unsigned IDX_W       = 20;
   localparam int unsigned KEY_W       = 32;
   localparam int unsigned BIN_W       = 11;
   localparam int unsigned CFG_W       = 21;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned EPOCH_BITS  = 6;

   localparam int unsigned TABLE_SLOTS_DEFAULT = 1024;
   localparam int unsigned INDEX_BITS_DEFAULT  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXAMPLE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENT_COUNT = 1'b1;

   localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;
   localparam logic [KEY_W-1:0] MAG_MASK  = 32'h7FFF_FFFF;
   localparam logic [KEY_W-1:0] EXP_MASK  = 32'h7F80_0000;
   localparam logic [KEY_W-1:0] MANT_MASK = 32'h007F_FFFF;

   typedef struct packed {
      logic             start_feature;
      logic [IDX_W-1:0] example_index;
      logic [KEY_W-1:0] feature_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_example_index;
      logic [BIN_W-1:0] bin_number;
      logic             opened_bin;
      logic             skipped;
      logic             overflow;
      logic [BIN_W-1:0] bins_in_use;
      logic             sparse_flag;
   } rsp_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] tag;
      logic [KEY_W-1:0]      key;
      logic [BIN_W-1:0]      bin;
   } slot_entry_type;

endpackage

### sv/dvba_chan_if.sv
// ----------------------------------------------------------------------------
// dvba_chan_if
// Valid/ready channel carrying one request or one result payload.
// ----------------------------------------------------------------------------
interface dvba_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/dvba_hash.sv
// ----------------------------------------------------------------------------
// dvba_hash
// Multiplicative hash of a key into a slot number of the table.
// ----------------------------------------------------------------------------
module dvba_hash #(
   parameter int unsigned TABLE_SLOTS = dvba_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dvba_pkg::KEY_W-1:0]      key,
   output logic [$clog2(TABLE_SLOTS)-1:0]  slot,
   output logic                            done
);
   localparam int unsigned SW      = $clog2(TABLE_SLOTS);
   localparam bit          IS_POW2 = (TABLE_SLOTS == (1 << SW));

   logic [dvba_pkg::KEY_W-1:0] prod_ff;
   logic [dvba_pkg::KEY_W-1:0] mixed;

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= key * dvba_pkg::HASH_MULT;
      end
   end

   assign mixed = prod_ff ^ (prod_ff >> 16);

   generate
      if (IS_POW2) begin : g_mask
         assign slot = mixed[SW-1:0];
         assign done = 1'b1;
      end else begin : g_rem
         localparam int unsigned RW    = SW + 1;
         localparam int unsigned DIG   = 4;
         localparam int unsigned STEPS = dvba_pkg::KEY_W / DIG;
         localparam int unsigned CW    = $clog2(STEPS);

         logic                       pend_ff;
         logic                       run_ff;
         logic                       done_ff;
         logic [CW-1:0]              step_ff;
         logic [RW-1:0]              rem_ff;
         logic [RW-1:0]              rem_in;
         logic [dvba_pkg::KEY_W-1:0] word_ff;

         // remainder by the table size, one digit of the hash a cycle
         always_comb begin
            logic [RW-1:0] r;
            r = rem_ff;
            for (int b = 0; b < DIG; b++) begin
               r = {r[RW-2:0], word_ff[dvba_pkg::KEY_W-1-b]};
               if (r >= RW'(TABLE_SLOTS)) begin
                  r = r - RW'(TABLE_SLOTS);
               end
            end
            rem_in = r;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               pend_ff <= 1'b0;
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
               step_ff <= '0;
            end else begin
               pend_ff <= start;
               if (start) begin
                  done_ff <= 1'b0;
                  run_ff  <= 1'b0;
               end else if (pend_ff) begin
                  run_ff  <= 1'b1;
                  step_ff <= '0;
               end else if (run_ff) begin
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == CW'(STEPS - 1)) begin
                     run_ff  <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (pend_ff) begin
               word_ff <= mixed;
               rem_ff  <= '0;
            end else if (run_ff) begin
               word_ff <= word_ff << DIG;
               rem_ff  <= rem_in;
            end
         end

         assign slot = rem_ff[SW-1:0];
         assign done = done_ff;
      end
   endgenerate

endmodule

### sv/dvba_slot_ram.sv
// ----------------------------------------------------------------------------
// dvba_slot_ram
// Slot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dvba_slot_ram #(
   parameter int unsigned DEPTH = dvba_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  dvba_pkg::slot_entry_type        wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output dvba_pkg::slot_entry_type        rd_data
);
   dvba_pkg::slot_entry_type mem [DEPTH];
   dvba_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/distinct_value_bin_assigner_top.sv
// ----------------------------------------------------------------------------
// distinct_value_bin_assigner_top
// Assigns each distinct float value of a feature a bin in order of first
// appearance, using a hash table with linear probing.
//
// Usage: requests arrive on req_chan (start_feature, example_index,
// feature_value); one result per request leaves on rsp_chan. The csr_ port
// writes example_count (index 0) and element_count (index 1); the user must
// write them only while idle, which the block itself does not enforce.
// Requests are handled one at a time. A request whose first probe resolves
// goes through accept, hash, table read and result load; every further probe
// re-reads the slot table, up to TABLE_SLOTS probes. With a table size that
// is not a power of two the hash also waits for the remainder unit. Sparse
// zero values skip the hash and the table.
// Table entries carry an epoch tag; start_feature advances the epoch, and
// every 63rd start_feature runs a clearing pass over all slots first.
// Reset: synchronous; a clearing pass over all slots follows, with
// req_chan.ready low; csr writes are taken throughout.
// Stall: the result register holds until taken; the next request may be
// accepted meanwhile and waits in its last step for the register to free.
// ----------------------------------------------------------------------------
module distinct_value_bin_assigner_top #(
   parameter int unsigned TABLE_SLOTS = dvba_pkg::TABLE_SLOTS_DEFAULT,
   parameter int unsigned INDEX_BITS  = dvba_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [dvba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dvba_pkg::CFG_W-1:0]       csr_wr_data,
   dvba_chan_if.sink                        req_chan,
   dvba_chan_if.source                      rsp_chan
);
   localparam int unsigned SW       = $clog2(TABLE_SLOTS);
   localparam int unsigned IDX_W    = dvba_pkg::IDX_W;
   localparam int unsigned IDX_KEEP = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
   localparam int unsigned BIN_W    = dvba_pkg::BIN_W;
   localparam int unsigned EB       = dvba_pkg::EPOCH_BITS;

   localparam logic [SW-1:0] SLOT_LAST   = SW'(TABLE_SLOTS - 1);
   localparam logic [EB-1:0] EPOCH_FIRST = EB'(1);
   localparam logic [EB-1:0] EPOCH_LAST  = '1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                 state_ff,  state_in;
   logic [EB-1:0]              epoch_ff,  epoch_in;
   logic [SW-1:0]              clr_ff,    clr_in;
   logic                       pend_ff,   pend_in;
   logic [BIN_W-1:0]           nbin_ff,   nbin_in;
   logic [dvba_pkg::CFG_W-1:0] excnt_ff;
   logic [dvba_pkg::CFG_W-1:0] elcnt_ff;
   logic                       rsp_vld_ff, rsp_vld_in;
   dvba_pkg::rsp_type          rsp_ff,    rsp_in;

   logic [dvba_pkg::KEY_W-1:0] key_ff,    key_in;
   logic [IDX_KEEP-1:0]        idx_ff,    idx_in;
   logic                       nan_ff,    nan_in;
   logic                       skip_ff,   skip_in;
   logic [SW-1:0]              slot_ff,   slot_in;
   logic [SW-1:0]              probe_ff,  probe_in;
   logic [BIN_W-1:0]           rbin_ff,   rbin_in;
   logic                       ropen_ff,  ropen_in;
   logic                       rovf_ff,   rovf_in;

   logic                       accept;
   logic                       is_zero;
   logic                       sparse;
   logic [dvba_pkg::KEY_W-1:0] key_norm;
   logic [SW-1:0]              hash_slot;
   logic                       hash_done;
   logic                       wr_en;
   logic [SW-1:0]              wr_addr;
   dvba_pkg::slot_entry_type   wr_data;
   logic                       rd_en;
   logic [SW-1:0]              rd_addr;
   dvba_pkg::slot_entry_type   rd_data;
   logic                       empty_slot;
   logic                       key_hit;
   logic                       out_free;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign is_zero          = (req_chan.payload.feature_value & dvba_pkg::MAG_MASK) == '0;
   assign sparse           = elcnt_ff < excnt_ff;
   assign key_norm         = is_zero ? '0 : req_chan.payload.feature_value;
   assign empty_slot       = rd_data.tag != epoch_ff;
   assign key_hit          = !nan_ff && (rd_data.key == key_ff);
   assign out_free         = !rsp_vld_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

   dvba_hash #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (key_norm),
      .slot  (hash_slot),
      .done  (hash_done)
   );

   dvba_slot_ram #(
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      epoch_in   = epoch_ff;
      clr_in     = clr_ff;
      pend_in    = pend_ff;
      nbin_in    = nbin_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      rsp_in     = rsp_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      nan_in     = nan_ff;
      skip_in    = skip_ff;
      slot_in    = slot_ff;
      probe_in   = probe_ff;
      rbin_in    = rbin_ff;
      ropen_in   = ropen_ff;
      rovf_in    = rovf_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_data    = '{tag: epoch_ff, key: key_ff, bin: nbin_ff};
      rd_en      = 1'b0;
      rd_addr    = slot_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SLOT_LAST) begin
               clr_in  = '0;
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_IDLE;
               end else if (skip_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_IDLE: begin
            if (accept) begin
               key_in   = key_norm;
               idx_in   = req_chan.payload.example_index[IDX_KEEP-1:0];
               nan_in   = ((req_chan.payload.feature_value & dvba_pkg::EXP_MASK)
                           == dvba_pkg::EXP_MASK)
                          && ((req_chan.payload.feature_value & dvba_pkg::MANT_MASK) != '0);
               skip_in  = sparse && is_zero;
               rbin_in  = '0;
               ropen_in = 1'b0;
               rovf_in  = 1'b0;
               state_in = (sparse && is_zero) ? S_DONE : S_HASH;
               if (req_chan.payload.start_feature) begin
                  nbin_in = BIN_W'(sparse);
                  if (epoch_ff == EPOCH_LAST) begin
                     epoch_in = EPOCH_FIRST;
                     pend_in  = 1'b1;
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               rd_en    = 1'b1;
               rd_addr  = hash_slot;
               slot_in  = hash_slot;
               probe_in = '0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (empty_slot) begin
               wr_en    = 1'b1;
               rbin_in  = nbin_ff;
               ropen_in = 1'b1;
               nbin_in  = nbin_ff + 1'b1;
               state_in = S_DONE;
            end else if (key_hit) begin
               rbin_in  = rd_data.bin;
               state_in = S_DONE;
            end else if (probe_ff == SLOT_LAST) begin
               rovf_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               // advance to the next slot, wrapping at the table end
               slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               rd_en    = 1'b1;
               rd_addr  = slot_in;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in                = 1'b1;
               rsp_in.out_example_index  = IDX_W'(idx_ff);
               rsp_in.bin_number         = rbin_ff;
               rsp_in.opened_bin         = ropen_ff;
               rsp_in.skipped            = skip_ff;
               rsp_in.overflow           = rovf_ff;
               rsp_in.bins_in_use        = nbin_ff;
               rsp_in.sparse_flag        = sparse;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         epoch_ff   <= EPOCH_FIRST;
         clr_ff     <= '0;
         pend_ff    <= 1'b0;
         nbin_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         epoch_ff   <= epoch_in;
         clr_ff     <= clr_in;
         pend_ff    <= pend_in;
         nbin_ff    <= nbin_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         excnt_ff <= '0;
         elcnt_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            dvba_pkg::CSR_EXAMPLE_COUNT: excnt_ff <= csr_wr_data;
            dvba_pkg::CSR_ELEMENT_COUNT: elcnt_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      nan_ff   <= nan_in;
      skip_ff  <= skip_in;
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      rbin_ff  <= rbin_in;
      ropen_ff <= ropen_in;
      rovf_ff  <= rovf_in;
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("epoch reached the invalid tag");

   a_bin_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP && empty_slot) |=> nbin_ff == BIN_W'($past(nbin_ff) + 1'b1))
      else $error("new bin did not advance the bin counter");

   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_ff.opened_bin && (rsp_ff.skipped || rsp_ff.overflow)))
      else $error("opened bin flagged together with skip or overflow");

endmodule

### tb/tb_distinct_value_bin_assigner_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distinct_value_bin_assigner_top
// Self-checking bench for the distinct value bin assigner. A scoreboard keeps
// its own hash dictionary, probed in the same order as the block, and predicts
// every result field: index, bin, new-bin and skip flags, table-full flag,
// bin count and mode. Stimulus covers dense and sparse features, signed zeros,
// NaNs, infinities, denormals, repeats, a completely filled table and register
// changes in the middle of a feature. Requests come in random bursts, and
// the result side stalls on its own random pattern, including one long stretch.
// ----------------------------------------------------------------------------
module tb_distinct_value_bin_assigner_top;
   import dvba_pkg::*;

   localparam int unsigned SLOTS       = 1024;
   localparam int unsigned FULL_BINS   = SLOTS + 1;
   localparam int unsigned IDLE_LIMIT  = 20000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned HOLD_AFTER  = 500;
   localparam int unsigned PHASE_ITEMS = 45;
   localparam logic [CFG_W-1:0] COUNT_MAX = 21'd1048576;

   class bin_dictionary_tracker;
      logic [KEY_W-1:0] key_tab [SLOTS];
      logic [BIN_W-1:0] bin_tab [SLOTS];
      bit               taken   [SLOTS];
      int unsigned      next_bin;
      logic [CFG_W-1:0] example_count;
      logic [CFG_W-1:0] element_count;
      rsp_type          results_due [$];
      int unsigned      errors, checked, n_req, n_opened, n_hit, n_skipped;
      int unsigned      n_overflow, n_nan, max_in_use;

      function new();
         next_bin      = 0;
         example_count = '0;
         element_count = '0;
         foreach (taken[i]) taken[i] = 1'b0;
      endfunction

      function void set_counts(logic [CFG_W-1:0] examples, logic [CFG_W-1:0] elements);
         example_count = examples;
         element_count = elements;
      endfunction

      function int unsigned home_slot(logic [KEY_W-1:0] k);
         logic [KEY_W-1:0] h;
         h = k * HASH_MULT;
         h = h ^ (h >> 16);
         return h % SLOTS;
      endfunction

      function int unsigned pending();
         return results_due.size();
      endfunction

      function void assign_bin(req_type r);
         rsp_type          want;
         logic [KEY_W-1:0] k;
         bit               sparse, zero, nan, done;
         int unsigned      h, s;
         sparse = element_count < example_count;
         k      = r.feature_value;
         zero   = (k & MAG_MASK) == '0;
         nan    = ((k & EXP_MASK) == EXP_MASK) && ((k & MANT_MASK) != '0);
         if (r.start_feature) begin
            foreach (taken[i]) taken[i] = 1'b0;
            next_bin = sparse ? 1 : 0;
         end
         want                   = '0;
         want.out_example_index = r.example_index;
         want.sparse_flag       = sparse;
         n_req++;
         if (nan) n_nan++;
         if (sparse && zero) begin
            want.skipped = 1'b1;
            n_skipped++;
         end else begin
            if (zero) k = '0;
            h    = home_slot(k);
            done = 1'b0;
            for (int i = 0; i < SLOTS && !done; i++) begin
               s = (h + i) % SLOTS;
               if (!taken[s]) begin
                  taken[s]        = 1'b1;
                  key_tab[s]      = k;
                  bin_tab[s]      = BIN_W'(next_bin);
                  want.bin_number = BIN_W'(next_bin);
                  want.opened_bin = 1'b1;
                  next_bin++;
                  n_opened++;
                  done = 1'b1;
               end else if (!nan && key_tab[s] == k) begin
                  want.bin_number = bin_tab[s];
                  n_hit++;
                  done = 1'b1;
               end
            end
            if (!done) begin
               want.overflow = 1'b1;
               n_overflow++;
            end
         end
         want.bins_in_use = BIN_W'(next_bin);
         if (next_bin > max_in_use) max_in_use = next_bin;
         results_due.push_back(want);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void compare_result(rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            $error("result with no request outstanding: %p", got);
            errors++;
            return;
         end
         want = results_due.pop_front();
         checked++;
         check_field("out_example_index", want.out_example_index, got.out_example_index);
         check_field("bin_number", want.bin_number, got.bin_number);
         check_field("opened_bin", want.opened_bin, got.opened_bin);
         check_field("skipped", want.skipped, got.skipped);
         check_field("overflow", want.overflow, got.overflow);
         check_field("bins_in_use", want.bins_in_use, got.bins_in_use);
         check_field("sparse_flag", want.sparse_flag, got.sparse_flag);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wr_data;

   dvba_chan_if #(.payload_type(req_type)) req_if ();
   dvba_chan_if #(.payload_type(rsp_type)) rsp_if ();

   bin_dictionary_tracker dict = new();
   int unsigned           burst_left = 0;

   distinct_value_bin_assigner_top #(
      .TABLE_SLOTS(SLOTS),
      .INDEX_BITS (IDX_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [KEY_W-1:0] random_value();
      int unsigned sel;
      logic        sign;
      sel  = $urandom_range(0, 99);
      sign = 1'($urandom_range(0, 1));
      if (sel < 15) return {sign, 31'h0};
      if (sel < 30) return {sign, 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      if (sel < 38) return {sign, 8'hFF, 23'h0};
      if (sel < 46) return {sign, 8'h00, 23'($urandom())};
      return $urandom();
   endfunction

   task automatic send_req(req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 16);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.payload <= r;
      req_if.valid   <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      dict.assign_bin(r);
   endtask

   task automatic send_item(bit start, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] value);
      req_type r;
      r.start_feature = start;
      r.example_index = idx;
      r.feature_value = value;
      send_req(r);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (dict.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_counts(logic [CFG_W-1:0] examples, logic [CFG_W-1:0] elements);
      csr_index   <= CSR_EXAMPLE_COUNT;
      csr_wr_data <= examples;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_index   <= CSR_ELEMENT_COUNT;
      csr_wr_data <= elements;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dict.set_counts(examples, elements);
   endtask

   task automatic run_directed();
      // reset counts, dense, no feature opened yet
      send_item(1'b0, 20'h00000, 32'h0000_0000);
      send_item(1'b0, 20'hFFFFF, 32'h8000_0000);
      send_item(1'b0, 20'h00001, 32'h7FC0_0000);
      send_item(1'b0, 20'h80000, 32'h7FC0_0000);
      send_item(1'b0, 20'h7FFFF, 32'hFFFF_FFFF);
      send_item(1'b0, 20'h12345, 32'h7F80_0000);
      send_item(1'b0, 20'h54321, 32'hFF80_0000);
      send_item(1'b0, 20'h0000F, 32'h7F80_0000);
      send_item(1'b0, 20'hAAAAA, 32'h3F80_0000);
      send_item(1'b0, 20'h55555, 32'h3F80_0000);
      send_item(1'b1, 20'h00010, 32'hFFFF_FFFF);
      drain();
      set_counts(COUNT_MAX, '0);
      send_item(1'b1, 20'h00000, 32'h0000_0000);
      send_item(1'b0, 20'hFFFFF, 32'h8000_0000);
      send_item(1'b0, 20'h00002, 32'h0000_0001);
      send_item(1'b0, 20'h00003, 32'h8000_0001);
      send_item(1'b0, 20'h00004, 32'h7F80_0001);
      send_item(1'b0, 20'h00005, 32'hFF80_0001);
      send_item(1'b0, 20'h00006, 32'h0000_0001);
      send_item(1'b0, 20'h00007, 32'h7F7F_FFFF);
      drain();
      // switch to dense without a new feature
      set_counts('0, COUNT_MAX);
      send_item(1'b0, 20'h00008, 32'h8000_0000);
      send_item(1'b1, 20'h00009, 32'h8000_0000);
      send_item(1'b0, 20'h0000A, 32'h0000_0000);
      send_item(1'b0, 20'h0000B, 32'h7FC0_0000);
   endtask

   task automatic fill_table();
      logic [KEY_W-1:0] seen [$];
      logic [KEY_W-1:0] value;
      int unsigned      extra, sel;
      bit               start;
      extra = 0;
      start = 1'b1;
      while (extra < 16) begin
         sel = $urandom_range(0, 39);
         if (sel == 0)
            value = {1'($urandom_range(0, 1)), 31'h0};
         else if (sel <= 2 && seen.size() > 0)
            value = seen[$urandom_range(0, seen.size() - 1)];
         else
            value = $urandom();
         seen.push_back(value);
         send_item(start, IDX_W'($urandom_range(0, 20'hFFFFF)), value);
         start = 1'b0;
         if (dict.next_bin >= FULL_BINS) extra++;
      end
   endtask

   task automatic run_features(int unsigned n_items, bit open_fresh);
      logic [KEY_W-1:0] pool [8];
      logic [KEY_W-1:0] value;
      int unsigned      sent, size;
      bit               first, start;
      sent  = 0;
      first = 1'b1;
      while (sent < n_items) begin
         size = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
         foreach (pool[i]) pool[i] = random_value();
         for (int k = 0; k < size && sent < n_items; k++) begin
            if (k == 0)
               start = first ? open_fresh : ($urandom_range(0, 19) != 0);
            else
               start = ($urandom_range(0, 39) == 0);
            value = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)] : random_value();
            send_item(start, IDX_W'($urandom_range(0, 20'hFFFFF)), value);
            sent++;
         end
         first = 1'b0;
      end
   endtask

   // result side: random stall pattern plus one long hold-off
   initial begin
      int unsigned mode, mode_left, hold_left;
      bit          hold_done;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) dict.compare_result(rsp_if.payload);
         if (!hold_done && dict.checked >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               quiet, dict.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] examples;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_EXAMPLE_COUNT;
      csr_wr_data    <= '0;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      drain();
      examples = CFG_W'($urandom_range(1, COUNT_MAX));
      set_counts(examples, CFG_W'($urandom_range(0, examples - 1)));
      fill_table();

      drain();
      set_counts('0, COUNT_MAX);
      run_features(PHASE_ITEMS, 1'b1);

      drain();
      set_counts(COUNT_MAX, COUNT_MAX - 1);
      run_features(PHASE_ITEMS, 1'b0);

      drain();
      examples = CFG_W'($urandom_range(0, COUNT_MAX));
      set_counts(examples, examples);
      run_features(PHASE_ITEMS, 1'b1);

      drain();
      examples = CFG_W'($urandom_range(1, COUNT_MAX));
      set_counts(examples, examples - 1);
      run_features(PHASE_ITEMS, 1'b0);

      drain();
      set_counts(CFG_W'($urandom_range(0, COUNT_MAX)), CFG_W'($urandom_range(0, COUNT_MAX)));
      run_features(PHASE_ITEMS, 1'b1);

      drain();
      $display("Covered %0d requests: %0d new bins, %0d repeats, %0d skipped zeros, %0d NaNs.",
               dict.n_req, dict.n_opened, dict.n_hit, dict.n_skipped, dict.n_nan);
      $display("Peak bins in use %0d, %0d table-full results, %0d checked, %0d mismatches.",
               dict.max_in_use, dict.n_overflow, dict.checked, dict.errors);
      if (dict.errors == 0 && dict.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
